// File: hw/rtl/lrs_pkg.sv
// shared types and constants of the radix sorter
`default_nettype none
package lrs_pkg;

  localparam int unsigned ValueW  = 31;
  localparam int unsigned RadixW  = 11;
  localparam int unsigned RoundsW = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 11;

  localparam logic [CfgIdxW-1:0] REG_RADIX  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ROUNDS = 2'd1;

  localparam logic [RadixW-1:0]  RADIX_RST  = 11'd10;
  localparam logic [RoundsW-1:0] ROUNDS_RST = 6'd3;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last_in;
  } in_word_t;

  typedef struct packed {
    logic [ValueW-1:0] sorted_value;
    logic              last_out;
    logic              overflowed;
  } out_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/lsd_radix_sorter.sv
// lsd radix sorter: load, count / prefix / scatter rounds in memories, then emit
// loading takes one word per cycle while idle; the last word starts the sort.
// each round clears the buckets, counts each item's digit with a bit-serial
// 31-step divider, forms prefix sums and scatters the items into the other bank.
// results follow one word at a time, never back to back; the receiver cannot stall.
// async active-low reset clears control state; memories hold no reset value.
`default_nettype none
module lsd_radix_sorter
  import lrs_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned MAX_RADIX = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               start,
  input  wire in_word_t           in_i,
  output logic                    busy,
  output logic                    res_valid_o,
  output out_word_t               res_o
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned RW = $clog2(MAX_RADIX);
  localparam int unsigned BW = $clog2(MAX_RADIX + 1);
  localparam int unsigned SW = $clog2(ValueW);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CNT_RD, S_DIV_LD, S_DIV, S_INC_RD, S_INC_WR,
    S_PFX_RD, S_PFX_WR, S_SC_RD, S_SC_CRD, S_SC_WR, S_OUT_RD, S_OUT
  } state_e;

  state_e             state_q;
  logic [RadixW-1:0]  radix_q;
  logic [RoundsW-1:0] rounds_q, round_q;
  logic [CW-1:0]      count_q, idx_q;
  logic               ovf_q, bank_q;
  logic [BW-1:0]      bkt_q;
  logic [CW-1:0]      run_q;
  logic [ValueW-1:0]  dq_q, hold_val_q, hold_nq_q;
  logic [BW-1:0]      rem_q;
  logic [SW-1:0]      step_q;
  logic [RW-1:0]      dig_q;

  // memory ports
  logic              val_we, q_we, nq_we, dig_we, cnt_we;
  logic [IW:0]       val_wa, val_ra, q_wa, q_ra;
  logic [IW-1:0]     item_ra, item_wa;
  logic [RW-1:0]     cnt_wa, cnt_ra;
  logic [ValueW-1:0] val_wd, q_wd, nq_wd;
  logic [RW-1:0]     dig_wd;
  logic [CW-1:0]     cnt_wd;
  logic [ValueW-1:0] val_rd_q, q_rd_q, nq_rd_q;
  logic [RW-1:0]     dig_rd_q;
  logic [CW-1:0]     cnt_rd_q;

  logic [ValueW-1:0] val_mem [2*MAX_ITEMS];
  logic [ValueW-1:0] q_mem   [2*MAX_ITEMS];
  logic [ValueW-1:0] nq_mem  [MAX_ITEMS];
  logic [RW-1:0]     dig_mem [MAX_ITEMS];
  logic [CW-1:0]     cnt_mem [MAX_RADIX];

  logic [31:0]   radix_ext;
  logic [BW-1:0] base;
  logic          accept, idx_end;
  logic [BW:0]   trial;
  logic          fits;

  assign radix_ext = 32'(radix_q);
  always_comb begin
    if (radix_ext == 32'd0) begin
      base = BW'(1);
    end else if (radix_ext > 32'(MAX_RADIX)) begin
      base = BW'(MAX_RADIX);
    end else begin
      base = BW'(radix_ext);
    end
  end

  assign accept  = start && !busy;
  assign idx_end = (idx_q + CW'(1)) == count_q;
  assign trial   = {rem_q, dq_q[ValueW-1]};
  assign fits    = trial >= {1'b0, base};

  always_comb begin
    val_we  = 1'b0;
    q_we    = 1'b0;
    nq_we   = 1'b0;
    dig_we  = 1'b0;
    cnt_we  = 1'b0;
    val_wa  = {1'b0, count_q[IW-1:0]};
    q_wa    = {1'b0, count_q[IW-1:0]};
    val_wd  = in_i.value;
    q_wd    = in_i.value;
    val_ra  = {bank_q, idx_q[IW-1:0]};
    q_ra    = {bank_q, idx_q[IW-1:0]};
    item_ra = idx_q[IW-1:0];
    item_wa = idx_q[IW-1:0];
    nq_wd   = dq_q;
    dig_wd  = rem_q[RW-1:0];
    cnt_ra  = bkt_q[RW-1:0];
    cnt_wa  = bkt_q[RW-1:0];
    cnt_wd  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (count_q < CW'(MAX_ITEMS))) begin
          val_we = 1'b1;
          q_we   = 1'b1;
        end
      end
      S_CLR: cnt_we = 1'b1;
      S_INC_RD: begin
        nq_we  = 1'b1;
        dig_we = 1'b1;
        cnt_ra = rem_q[RW-1:0];
      end
      S_INC_WR: begin
        cnt_we = 1'b1;
        cnt_wa = rem_q[RW-1:0];
        cnt_wd = cnt_rd_q + CW'(1);
      end
      S_PFX_WR: begin
        cnt_we = 1'b1;
        cnt_wd = run_q;
      end
      S_SC_CRD: cnt_ra = dig_rd_q;
      S_SC_WR: begin
        val_we = 1'b1;
        q_we   = 1'b1;
        val_wa = {~bank_q, cnt_rd_q[IW-1:0]};
        q_wa   = {~bank_q, cnt_rd_q[IW-1:0]};
        val_wd = hold_val_q;
        q_wd   = hold_nq_q;
        cnt_we = 1'b1;
        cnt_wa = dig_q;
        cnt_wd = cnt_rd_q + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    val_rd_q <= val_mem[val_ra];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nq_we) nq_mem[item_wa] <= nq_wd;
    nq_rd_q <= nq_mem[item_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dig_we) dig_mem[item_wa] <= dig_wd;
    dig_rd_q <= dig_mem[item_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= RADIX_RST;
      rounds_q    <= ROUNDS_RST;
      round_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      bank_q      <= 1'b0;
      bkt_q       <= '0;
      run_q       <= '0;
      step_q      <= '0;
      dq_q        <= '0;
      rem_q       <= '0;
      dig_q       <= '0;
      hold_val_q  <= '0;
      hold_nq_q   <= '0;
      busy        <= 1'b0;
      res_valid_o <= 1'b0;
      res_o       <= '0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RADIX) radix_q <= cfg_data_i[RadixW-1:0];
        if (cfg_idx_i == REG_ROUNDS) rounds_q <= cfg_data_i[RoundsW-1:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            // a full store on the last word still sorts what it holds
            if (count_q < CW'(MAX_ITEMS)) begin
              count_q <= count_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_i.last_in) begin
              busy    <= 1'b1;
              round_q <= '0;
              idx_q   <= '0;
              bkt_q   <= '0;
              state_q <= (rounds_q == '0) ? S_OUT_RD : S_CLR;
            end
          end
        end
        S_CLR: begin
          if (bkt_q == base - BW'(1)) begin
            bkt_q   <= '0;
            idx_q   <= '0;
            state_q <= S_CNT_RD;
          end else begin
            bkt_q <= bkt_q + BW'(1);
          end
        end
        S_CNT_RD: state_q <= S_DIV_LD;
        S_DIV_LD: begin
          dq_q    <= q_rd_q;
          rem_q   <= '0;
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          rem_q  <= fits ? BW'(trial - {1'b0, base}) : trial[BW-1:0];
          dq_q   <= {dq_q[ValueW-2:0], fits};
          step_q <= step_q + SW'(1);
          if (step_q == SW'(ValueW - 1)) state_q <= S_INC_RD;
        end
        S_INC_RD: state_q <= S_INC_WR;
        S_INC_WR: begin
          if (idx_end) begin
            bkt_q   <= '0;
            run_q   <= '0;
            state_q <= S_PFX_RD;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_CNT_RD;
          end
        end
        S_PFX_RD: state_q <= S_PFX_WR;
        S_PFX_WR: begin
          run_q <= run_q + cnt_rd_q;
          if (bkt_q == base - BW'(1)) begin
            idx_q   <= '0;
            state_q <= S_SC_RD;
          end else begin
            bkt_q   <= bkt_q + BW'(1);
            state_q <= S_PFX_RD;
          end
        end
        S_SC_RD: state_q <= S_SC_CRD;
        S_SC_CRD: begin
          hold_val_q <= val_rd_q;
          hold_nq_q  <= nq_rd_q;
          dig_q      <= dig_rd_q;
          state_q    <= S_SC_WR;
        end
        S_SC_WR: begin
          if (idx_end) begin
            bank_q  <= ~bank_q;
            idx_q   <= '0;
            bkt_q   <= '0;
            round_q <= round_q + RoundsW'(1);
            state_q <= (round_q + RoundsW'(1) == rounds_q) ? S_OUT_RD : S_CLR;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_SC_RD;
          end
        end
        S_OUT_RD: state_q <= S_OUT;
        S_OUT: begin
          res_valid_o        <= 1'b1;
          res_o.sorted_value <= val_rd_q;
          res_o.last_out     <= idx_end;
          res_o.overflowed   <= ovf_q;
          if (idx_end) begin
            count_q <= '0;
            ovf_q   <= 1'b0;
            bank_q  <= 1'b0;
            busy    <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_OUT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lrs_checker.sv
// port-level checks of the radix sorter and their bind
`default_nettype none
module lrs_checker
  import lrs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire in_word_t  in_i,
  input wire logic      busy,
  input wire logic      res_valid_o,
  input wire out_word_t res_o
);

  // the last loaded word starts the sort
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.last_in |=> busy)
    else $error("sort did not start on last word");

  // words within a batch follow each other at an even spacing
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_out |-> ##2 res_valid_o)
    else $error("sorted words not evenly spaced");

  a_no_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("sorted words back to back");

  // overflow mark is the same across a batch
  a_ovf_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(res_valid_o, 2) && !$past(res_o.last_out, 2)
      |-> res_o.overflowed == $past(res_o.overflowed, 2))
    else $error("overflow mark changed within a batch");

  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_out |-> busy)
    else $error("idle in the middle of a batch");

endmodule

bind lsd_radix_sorter lrs_checker u_lrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .in_i        (in_i),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench of the lsd radix sorter
`timescale 1ns / 100ps
module tb_top;
  import lrs_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned TopRadix = 1024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic start = 1'b0;
  in_word_t in_i = '0;
  logic busy;
  logic res_valid_o;
  out_word_t res_o;

  lsd_radix_sorter uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .start(start), .in_i(in_i), .busy(busy),
    .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  in_word_t pending_words[$];
  out_word_t sorted_words[$];
  logic [ValueW-1:0] batch_vals[$];
  bit batch_ovf;
  bit taken;
  bit failed;
  int unsigned idle_pct;
  logic [RadixW-1:0] cur_radix;
  logic [RoundsW-1:0] cur_rounds;

  // stable counting sort by digit, least significant first
  function automatic void digit_sort(ref logic [ValueW-1:0] vals[$]);
    logic [ValueW-1:0] nxt[$];
    longint unsigned base, div;
    base = (cur_radix == 0) ? 1 : (cur_radix > TopRadix) ? TopRadix : cur_radix;
    div = 1;
    for (int r = 0; r < cur_rounds; r++) begin
      if (div > 64'h7FFF_FFFF) break;
      nxt.delete();
      for (longint unsigned d = 0; d < base; d++)
        foreach (vals[i])
          if ((vals[i] / div) % base == d) nxt.push_back(vals[i]);
      vals = nxt;
      div = div * base;
    end
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!start || taken)) begin
      taken = 1'b0;
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_i <= pending_words.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t w;
    if (rst_ni && start && !busy) begin
      taken = 1'b1;
      if (batch_vals.size() < Depth) batch_vals.push_back(in_i.value);
      else batch_ovf = 1'b1;
      if (in_i.last_in) begin
        digit_sort(batch_vals);
        foreach (batch_vals[i]) begin
          w.sorted_value = batch_vals[i];
          w.last_out = (i == batch_vals.size() - 1);
          w.overflowed = batch_ovf;
          sorted_words.push_back(w);
        end
        batch_vals.delete();
        batch_ovf = 1'b0;
      end
    end
    if (rst_ni && res_valid_o) begin
      if (sorted_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $realtime, res_o);
        failed = 1'b1;
      end else begin
        w = sorted_words.pop_front();
        if (res_o.sorted_value !== w.sorted_value)
          $display("%0t: sorted_value expected %h actual %h", $realtime,
                   w.sorted_value, res_o.sorted_value);
        if (res_o.last_out !== w.last_out)
          $display("%0t: last_out expected %b actual %b", $realtime,
                   w.last_out, res_o.last_out);
        if (res_o.overflowed !== w.overflowed)
          $display("%0t: overflowed expected %b actual %b", $realtime,
                   w.overflowed, res_o.overflowed);
        if (res_o !== w) failed = 1'b1;
      end
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || start || sorted_words.size() > 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == REG_RADIX) cur_radix = data[RadixW-1:0];
    if (idx == REG_ROUNDS) cur_rounds = data[RoundsW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_batch(int n, bit wide);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.value = ValueW'($urandom());
      if (!wide) w.value = ValueW'(w.value & ((32'h1 << $urandom_range(31, 1)) - 1));
      w.last_in = (i == n - 1);
      pending_words.push_back(w);
    end
  endtask

  task automatic push_val(logic [ValueW-1:0] v, logic lst);
    in_word_t w;
    w.value = v;
    w.last_in = lst;
    pending_words.push_back(w);
  endtask

  int unsigned radixes[6] = '{10, 2, 1024, 0, 16, 2047};
  int unsigned rounds[6] = '{3, 32, 4, 63, 8, 0};
  int unsigned max_n[6] = '{16, 8, 12, 6, 16, 16};

  initial begin
    cur_radix = RADIX_RST;
    cur_rounds = ROUNDS_RST;
    idle_pct = 17;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: extremes, duplicates, single-word batch
    push_val('0, 1'b0);
    push_val('1, 1'b0);
    push_val(31'd5, 1'b0);
    push_val(31'd123, 1'b0);
    push_val(31'd5, 1'b1);
    push_val(31'h7FFF_FFFF, 1'b1);
    // radix zero acts as one: load order kept
    write_reg(REG_RADIX, '0);
    push_val(31'd9, 1'b0);
    push_val(31'd1, 1'b0);
    push_val(31'd4, 1'b1);
    // oversized radix saturates, with the most rounds
    write_reg(REG_RADIX, '1);
    write_reg(REG_ROUNDS, '1);
    push_val(31'h4000_0000, 1'b0);
    push_val(31'd1023, 1'b0);
    push_val(31'd1024, 1'b0);
    push_val('0, 1'b1);
    // zero rounds
    write_reg(REG_ROUNDS, '0);
    push_val(31'd3, 1'b0);
    push_val(31'd2, 1'b0);
    push_val(31'd1, 1'b1);
    write_reg(REG_RADIX, CfgW'(2));
    write_reg(REG_ROUNDS, CfgW'(32));
    push_val(31'h5555_5555, 1'b0);
    push_val(31'h2AAA_AAAA, 1'b0);
    push_val(31'd0, 1'b0);
    push_val(31'd1, 1'b1);
    drain();

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 17 : (p == 1) ? 86 : 0;
      for (int c = 0; c < 6; c++) begin
        write_reg(REG_RADIX, CfgW'(radixes[c]));
        write_reg(REG_ROUNDS, CfgW'(rounds[c]));
        push_batch($urandom_range(max_n[c], 1), 1'($urandom_range(1)));
        // full store, then dropped words including the last word
        if (c == 0 && p == 0) push_batch(64, 1'b1);
        if (c == 0 && p == 1) push_batch(65, 1'b0);
      end
    end
    drain();
    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
